// ===== hdl/mkh_pkg.sv =====
package mkh_pkg;

  localparam int          LENGTH_BITS_DEF = 16;
  localparam int          QUEUE_DEPTH_DEF = 4;
  localparam int          ENTRY_FIXED_W   = 37;
  localparam logic [31:0] MIX_MUL         = 32'h5bd1e995;
  localparam int          MIX_SHIFT       = 24;
  localparam int          FIN_SHIFT_A     = 13;
  localparam int          FIN_SHIFT_B     = 15;
  localparam logic [31:0] SEED_RESET      = 32'd5381;
  localparam logic [2:0]  NB_NONE         = 3'd0;
  localparam logic [2:0]  NB_FULL         = 3'd4;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL1,
    F_MUL2,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_RUN,
    B_FIN,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [31:0] mix_mul(input logic [31:0] a);
    logic [31:0] p;
    p = a * MIX_MUL;
    return p;
  endfunction

endpackage

// ===== hdl/mkh_if.sv =====
interface mkh_key_if #(
  parameter int LENGTH_BITS = mkh_pkg::LENGTH_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   first;
  logic                   last;
  logic [LENGTH_BITS-1:0] key_length;
  logic [31:0]            data_word;
  logic [2:0]             valid_bytes;

  modport source (output valid, first, last, key_length, data_word, valid_bytes,
                  input ready);
  modport sink (input valid, first, last, key_length, data_word, valid_bytes,
                output ready);
endinterface

interface mkh_hash_if ();
  logic        valid;
  logic        ready;
  logic [31:0] hash;
  logic        length_error;

  modport source (output valid, hash, length_error, input ready);
  modport sink (input valid, hash, length_error, output ready);
endinterface

interface mkh_cfg_if ();
  logic        valid;
  logic        ready;
  logic [31:0] hash_seed;

  modport source (output valid, hash_seed, input ready);
  modport sink (input valid, hash_seed, output ready);
endinterface

// ===== hdl/murmur2_key_hash_unit.sv =====
// channel  | dir | beat payload
// key_i    | in  | first, last, key_length, data_word, valid_bytes
// cfg_i    | in  | hash_seed
// hash_o   | out | hash, length_error
//
// Front takes one key beat at a time and holds key_i off until it is pushed; full words
// take two passes through its constant multiplier. A 4-entry queue feeds the back, which
// retires one word per cycle off a non-empty queue and then avalanches a last word.
// Reset clears the accumulator, byte balance and fault flag; seed goes to 5381.
// A stalled hash_o holds the back, which then fills the queue and stalls key_i.
module murmur2_key_hash_unit #(
  parameter int LENGTH_BITS = mkh_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = mkh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mkh_key_if.sink    key_i,
  mkh_cfg_if.sink    cfg_i,
  mkh_hash_if.source hash_o
);

  localparam int EntryW = LENGTH_BITS + mkh_pkg::ENTRY_FIXED_W;

  logic               push, pop;
  logic [EntryW-1:0]  push_data, pop_data;
  mkh_pkg::q_status_t q_status;

  mkh_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (key_i),
    .q_status_i (q_status),
    .push_o     (push),
    .push_data_o(push_data)
  );

  mkh_queue #(
    .DATA_W(EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .q_status_o (q_status)
  );

  mkh_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .hash_o    (hash_o),
    .q_status_i(q_status),
    .pop_o     (pop),
    .pop_data_i(pop_data)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_i.valid && key_i.ready) |=> !key_i.ready)
    else $error("front took a beat while busy");

  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty");

endmodule

// ===== hdl/mkh_front.sv =====
module mkh_front #(
  parameter int LENGTH_BITS = mkh_pkg::LENGTH_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  mkh_key_if.sink                                      key_i,
  input  mkh_pkg::q_status_t                           q_status_i,
  output logic                                         push_o,
  output logic [LENGTH_BITS+mkh_pkg::ENTRY_FIXED_W-1:0] push_data_o
);

  mkh_pkg::front_state_e  state_q, state_d;
  logic                   first_q, last_q;
  logic [LENGTH_BITS-1:0] klen_q;
  logic [2:0]             nb_q;
  logic [31:0]            word_q;
  logic [2:0]             nb_sat;

  function automatic logic [31:0] tail_mask(input logic [2:0] nb);
    logic [31:0] m;
    case (nb)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  assign nb_sat = (key_i.valid_bytes > mkh_pkg::NB_FULL) ? mkh_pkg::NB_FULL
                                                        : key_i.valid_bytes;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mkh_pkg::F_IDLE: begin
        if (key_i.valid) begin
          state_d = (nb_sat == mkh_pkg::NB_FULL) ? mkh_pkg::F_MUL1 : mkh_pkg::F_PUSH;
        end
      end
      mkh_pkg::F_MUL1: state_d = mkh_pkg::F_MUL2;
      mkh_pkg::F_MUL2: state_d = mkh_pkg::F_PUSH;
      mkh_pkg::F_PUSH: begin
        if (!q_status_i.full) begin
          state_d = mkh_pkg::F_IDLE;
        end
      end
      default: state_d = mkh_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    key_i.ready = (state_q == mkh_pkg::F_IDLE);
    push_o      = (state_q == mkh_pkg::F_PUSH) && !q_status_i.full;
    push_data_o = {first_q, last_q, nb_q, klen_q, word_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mkh_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // full words get the key premix: k*m, k^=k>>24, k*m
  always_ff @(posedge clk_i) begin
    case (state_q)
      mkh_pkg::F_IDLE: begin
        if (key_i.valid) begin
          first_q <= key_i.first;
          last_q  <= key_i.last;
          klen_q  <= key_i.key_length;
          nb_q    <= nb_sat;
          word_q  <= key_i.data_word & tail_mask(nb_sat);
        end
      end
      mkh_pkg::F_MUL1: word_q <= mkh_pkg::mix_mul(word_q);
      mkh_pkg::F_MUL2: word_q <= mkh_pkg::mix_mul(word_q ^ (word_q >> mkh_pkg::MIX_SHIFT));
      default: ;
    endcase
  end

endmodule

// ===== hdl/mkh_queue.sv =====
module mkh_queue #(
  parameter int DATA_W = 53,
  parameter int DEPTH  = mkh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [DATA_W-1:0]  push_data_i,
  input  logic               pop_i,
  output logic [DATA_W-1:0]  pop_data_o,
  output mkh_pkg::q_status_t q_status_o
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [IdxW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  assign q_status_o.full  = (count_q == CntW'(DEPTH));
  assign q_status_o.empty = (count_q == '0);
  assign pop_data_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/mkh_back.sv =====
module mkh_back #(
  parameter int LENGTH_BITS = mkh_pkg::LENGTH_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  mkh_cfg_if.sink                                      cfg_i,
  mkh_hash_if.source                                   hash_o,
  input  mkh_pkg::q_status_t                           q_status_i,
  output logic                                         pop_o,
  input  logic [LENGTH_BITS+mkh_pkg::ENTRY_FIXED_W-1:0] pop_data_i
);

  localparam int EntryW = LENGTH_BITS + mkh_pkg::ENTRY_FIXED_W;

  mkh_pkg::back_state_e   state_q, state_d;
  logic [31:0]            seed_q;
  logic [31:0]            acc_q, acc_d;
  logic [LENGTH_BITS-1:0] bal_q, bal_d;
  logic                   fault_q, fault_d;
  logic [31:0]            fin_q;
  logic                   err_q;
  logic                   out_valid_q, out_valid_d;
  logic [31:0]            out_hash_q;
  logic                   out_err_q;
  logic                   out_load;

  logic                   e_first, e_last;
  logic [2:0]             e_nb;
  logic [LENGTH_BITS-1:0] e_klen, nb_ext;
  logic [31:0]            e_word;
  logic [31:0]            acc_base, mul_in, prod;
  logic [LENGTH_BITS-1:0] bal_base;
  logic                   fault_base, e_full, over;

  assign e_first = pop_data_i[EntryW-1];
  assign e_last  = pop_data_i[EntryW-2];
  assign e_nb    = pop_data_i[EntryW-3 -: 3];
  assign e_klen  = pop_data_i[32 +: LENGTH_BITS];
  assign e_word  = pop_data_i[31:0];

  always_comb begin
    acc_base   = e_first ? (seed_q ^ 32'(e_klen)) : acc_q;
    bal_base   = e_first ? e_klen : bal_q;
    fault_base = e_first ? 1'b0 : fault_q;
    e_full     = (e_nb == mkh_pkg::NB_FULL);
    nb_ext     = LENGTH_BITS'(e_nb);
    over       = nb_ext > bal_base;
    mul_in     = e_full ? acc_base : (acc_base ^ e_word);
    prod       = mkh_pkg::mix_mul(mul_in);

    acc_d   = acc_q;
    bal_d   = bal_q;
    fault_d = fault_q;
    if (pop_o) begin
      if (e_full) begin
        acc_d = prod ^ e_word;
      end else if (e_nb == mkh_pkg::NB_NONE) begin
        acc_d = acc_base;
      end else begin
        acc_d = prod;
      end
      bal_d   = over ? '0 : (bal_base - nb_ext);
      fault_d = fault_base | over | (!e_last && !e_full);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mkh_pkg::B_RUN: begin
        if (!q_status_i.empty && e_last) begin
          state_d = mkh_pkg::B_FIN;
        end
      end
      mkh_pkg::B_FIN: state_d = mkh_pkg::B_OUT;
      mkh_pkg::B_OUT: begin
        if (!out_valid_q || hash_o.ready) begin
          state_d = mkh_pkg::B_RUN;
        end
      end
      default: state_d = mkh_pkg::B_RUN;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == mkh_pkg::B_RUN) && !q_status_i.empty;
    out_load    = (state_q == mkh_pkg::B_OUT) && (!out_valid_q || hash_o.ready);
    out_valid_d = (out_valid_q && !hash_o.ready) || out_load;
    cfg_i.ready = 1'b1;
    hash_o.valid        = out_valid_q;
    hash_o.hash         = out_hash_q;
    hash_o.length_error = out_err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mkh_pkg::B_RUN;
      seed_q      <= mkh_pkg::SEED_RESET;
      acc_q       <= '0;
      bal_q       <= '0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      bal_q       <= bal_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        seed_q <= cfg_i.hash_seed;
      end
    end
  end

  // final avalanche split around the multiply
  always_ff @(posedge clk_i) begin
    if (state_q == mkh_pkg::B_FIN) begin
      fin_q <= mkh_pkg::mix_mul(acc_q ^ (acc_q >> mkh_pkg::FIN_SHIFT_A));
      err_q <= fault_q || (bal_q != '0);
    end
    if (out_load) begin
      out_hash_q <= fin_q ^ (fin_q >> mkh_pkg::FIN_SHIFT_B);
      out_err_q  <= err_q;
    end
  end

endmodule
